// ===== design/crlr_pkg.sv =====
`default_nettype none

package crlr_pkg;

    // Fixed field widths of the streams and the register port
    localparam int ELEMS       = 8;
    localparam int ELEM_W      = 8;
    localparam int RANK_W      = 49;
    localparam int USIZE_W     = 9;
    localparam int SSIZE_W     = 4;
    localparam int IN_TDATA_W  = ELEMS * ELEM_W;
    localparam int OUT_TDATA_W = 56;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Defaults for the top-level parameters
    localparam int MAX_SET_DEF      = 8;
    localparam int MAX_UNIVERSE_DEF = 256;

    // Register reset values
    localparam logic [USIZE_W-1:0] USIZE_RST = 9'd256;
    localparam logic [SSIZE_W-1:0] SSIZE_RST = 4'd1;

    // Register word index (paddr[2])
    typedef enum logic [0:0] {
        REG_UNIVERSE = 1'b0,
        REG_SET_SIZE = 1'b1
    } t_reg_idx;

    typedef logic [ELEM_W-1:0] t_elem;
    typedef logic [RANK_W-1:0] t_rank;

endpackage

`default_nettype wire

// ===== design/crlr_ram.sv =====
`default_nettype none

module crlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/crlr_fill.sv =====
`default_nettype none

module crlr_fill #(
    parameter int MAX_SET      = crlr_pkg::MAX_SET_DEF,
    parameter int MAX_UNIVERSE = crlr_pkg::MAX_UNIVERSE_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    output logic                                              o_busy,
    output logic                                              o_we,
    output logic [$clog2(MAX_UNIVERSE+1)-1:0]                 o_waddr,
    output logic [(MAX_SET+1)*crlr_pkg::RANK_W-1:0]           o_wdata
);

    localparam int ROWS = MAX_UNIVERSE + 1;
    localparam int AW   = $clog2(ROWS);
    localparam int NCOL = MAX_SET + 1;
    localparam int RK   = crlr_pkg::RANK_W;
    localparam int RW   = NCOL * RK;

    logic          r_busy;
    logic [AW-1:0] r_row;
    logic [RW-1:0] r_prev;
    logic [RW-1:0] n_row;

    // Pascal row m from row m-1, all columns in parallel, kept mod 2^RANK_W
    always_comb begin
        n_row = '0;
        n_row[0 +: RK] = RK'(1);
        if (r_row != '0) begin
            for (int k = 1; k < NCOL; k++) begin
                n_row[k*RK +: RK] = r_prev[(k-1)*RK +: RK] + r_prev[k*RK +: RK];
            end
        end
    end

    // Row counter: one row per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (r_busy) begin
            r_row <= r_row + 1'b1;
            if (r_row == AW'(ROWS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_prev <= n_row;
        end
    end

    assign o_busy  = r_busy;
    assign o_we    = r_busy;
    assign o_waddr = r_row;
    assign o_wdata = n_row;

endmodule

`default_nettype wire

// ===== design/crlr_check.sv =====
`default_nettype none

module crlr_check #(
    parameter int MAX_SET      = crlr_pkg::MAX_SET_DEF,
    parameter int MAX_UNIVERSE = crlr_pkg::MAX_UNIVERSE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_ce,
    input  wire logic                                i_load,
    input  wire crlr_pkg::t_elem                     i_elem [crlr_pkg::ELEMS],
    input  wire logic [crlr_pkg::USIZE_W-1:0]        i_usize,
    input  wire logic [crlr_pkg::SSIZE_W-1:0]        i_ssize,
    output logic                                     o_valid,
    output logic                                     o_bad,
    output logic                                     o_use [(MAX_SET < crlr_pkg::ELEMS) ?
                                                               MAX_SET : crlr_pkg::ELEMS],
    output logic [$clog2(MAX_SET+1)-1:0]             o_col [(MAX_SET < crlr_pkg::ELEMS) ?
                                                               MAX_SET : crlr_pkg::ELEMS],
    output logic [$clog2(MAX_UNIVERSE+1)-1:0]        o_addr [(MAX_SET < crlr_pkg::ELEMS) ?
                                                               MAX_SET : crlr_pkg::ELEMS],
    output logic [$clog2(MAX_UNIVERSE+1)-1:0]        o_top_addr,
    output logic [$clog2(MAX_SET+1)-1:0]             o_top_col
);

    localparam int NLANE = (MAX_SET < crlr_pkg::ELEMS) ? MAX_SET : crlr_pkg::ELEMS;
    localparam int AW    = $clog2(MAX_UNIVERSE + 1);
    localparam int CW    = $clog2(MAX_SET + 1);

    logic [AW-1:0] uni_eff;
    logic          n_bad;
    logic          n_use      [NLANE];
    logic [CW-1:0] n_col      [NLANE];
    logic [AW-1:0] n_addr     [NLANE];
    logic [AW-1:0] n_top_addr;
    logic [CW-1:0] n_top_col;

    logic          r_valid;
    logic          r_bad;
    logic          r_use      [NLANE];
    logic [CW-1:0] r_col      [NLANE];
    logic [AW-1:0] r_addr     [NLANE];
    logic [AW-1:0] r_top_addr;
    logic [CW-1:0] r_top_col;

    // Range and order checks, then per-lane row m = n-1-e_i and column k = p-i
    always_comb begin
        uni_eff = (32'(i_usize) > MAX_UNIVERSE) ? AW'(MAX_UNIVERSE) : AW'(i_usize);
        n_bad   = (i_ssize == '0) || (32'(i_ssize) > MAX_SET) ||
                  (32'(i_ssize) > crlr_pkg::ELEMS);
        for (int i = 0; i < NLANE; i++) begin
            n_use[i] = 32'(i_ssize) > i;
            if (n_use[i] && (32'(i_elem[i]) >= 32'(uni_eff))) begin
                n_bad = 1'b1;
            end
        end
        for (int i = 1; i < NLANE; i++) begin
            if (n_use[i] && (i_elem[i] <= i_elem[i-1])) begin
                n_bad = 1'b1;
            end
        end
        for (int i = 0; i < NLANE; i++) begin
            if (n_use[i] && !n_bad) begin
                n_addr[i] = AW'(32'(uni_eff) - 32'(i_elem[i]) - 1);
                n_col[i]  = CW'(32'(i_ssize) - i);
            end else begin
                n_addr[i] = '0;
                n_col[i]  = '0;
            end
        end
        // Total count C(n, p) of the subsets
        n_top_addr = n_bad ? '0 : uni_eff;
        n_top_col  = n_bad ? '0 : CW'(i_ssize);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_bad      <= n_bad;
            r_top_addr <= n_top_addr;
            r_top_col  <= n_top_col;
            for (int i = 0; i < NLANE; i++) begin
                r_use[i]  <= n_use[i];
                r_col[i]  <= n_col[i];
                r_addr[i] <= n_addr[i];
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_bad      = r_bad;
    assign o_use      = r_use;
    assign o_col      = r_col;
    assign o_addr     = r_addr;
    assign o_top_addr = r_top_addr;
    assign o_top_col  = r_top_col;

endmodule

`default_nettype wire

// ===== design/crlr_sum.sv =====
`default_nettype none

module crlr_sum #(
    parameter int MAX_SET = crlr_pkg::MAX_SET_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_bad,
    input  wire crlr_pkg::t_rank i_top,
    input  wire crlr_pkg::t_rank i_term [(MAX_SET < crlr_pkg::ELEMS) ?
                                           MAX_SET : crlr_pkg::ELEMS],
    output logic                 o_valid,
    input  wire logic            i_ready,
    output crlr_pkg::t_rank      o_rank,
    output logic                 o_bad
);

    localparam int NLANE = (MAX_SET < crlr_pkg::ELEMS) ? MAX_SET : crlr_pkg::ELEMS;
    localparam int L     = $clog2(NLANE);
    localparam int NL    = 1 << L;
    localparam int RK    = crlr_pkg::RANK_W;

    crlr_pkg::t_rank leaf  [NL];
    logic            stg_ce [L+1];
    logic            ce_out;

    logic            r_v    [L+1];
    logic            r_b    [L+1];
    crlr_pkg::t_rank r_top  [L+1];
    crlr_pkg::t_rank r_lvl  [L+1][NL];
    logic            r_ov;
    logic            r_obad;
    crlr_pkg::t_rank r_orank;

    // Leaves padded with zeros to a power of two
    always_comb begin
        for (int j = 0; j < NL; j++) begin
            leaf[j] = '0;
        end
        for (int j = 0; j < NLANE; j++) begin
            leaf[j] = i_term[j];
        end
    end

    // A stage loads when it is empty or the one after it loads
    always_comb begin
        ce_out    = !r_ov || i_ready;
        stg_ce[L] = !r_v[L] || ce_out;
        for (int l = L - 1; l >= 0; l--) begin
            stg_ce[l] = !r_v[l] || stg_ce[l+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l <= L; l++) begin
                r_v[l] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            if (stg_ce[0]) begin
                r_v[0] <= i_valid;
            end
            for (int l = 1; l <= L; l++) begin
                if (stg_ce[l]) begin
                    r_v[l] <= r_v[l-1];
                end
            end
            if (ce_out) begin
                r_ov <= r_v[L];
            end
        end
    end

    // Registered adder tree, one level per stage; final stage forms C(n,p)-1-sum
    always_ff @(posedge i_clk) begin
        if (stg_ce[0]) begin
            r_b[0]   <= i_bad;
            r_top[0] <= i_top;
            for (int j = 0; j < NL; j++) begin
                r_lvl[0][j] <= leaf[j];
            end
        end
        for (int l = 1; l <= L; l++) begin
            if (stg_ce[l]) begin
                r_b[l]   <= r_b[l-1];
                r_top[l] <= r_top[l-1];
                for (int j = 0; j < (NL >> l); j++) begin
                    r_lvl[l][j] <= r_lvl[l-1][2*j] + r_lvl[l-1][2*j+1];
                end
            end
        end
        if (ce_out) begin
            r_obad  <= r_b[L];
            r_orank <= r_b[L] ? '0 : (r_top[L] - RK'(1) - r_lvl[L][0]);
        end
    end

    assign o_ready = stg_ce[0];
    assign o_valid = r_ov;
    assign o_rank  = r_orank;
    assign o_bad   = r_obad;

endmodule

`default_nettype wire

// ===== design/combination_lexicographic_rank_core.sv =====
// Lexicographic rank of a sorted subset.
// Slave stream: one request carries elem_0..elem_7 (8 bits each, elem_0 in the
// low byte); only the first set_size indices are used. Master stream: one
// result per request, rank in tdata[48:0], bad_set in tuser[0] (rank is 0 then).
// APB registers: universe_size at 0x0, set_size at 0x4; write them only while
// the block is idle.
// The rank is C(n,p) - 1 - sum_i C(n-1-e_i, p-i). The binomial rows sit in one
// RAM copy per lane plus one for C(n,p), each with a registered read.
// Pipeline stages in order: check stage, RAM read, leaf stage, one stage per
// adder-tree level, output register.
// Throughput: one request per cycle; the pipeline keeps moving into its empty
// stages while the output waits, and stalls without loss when the receiver
// holds tready low.
// Reset: the table is built by Pascal's rule, one row per cycle, over all
// MAX_UNIVERSE+1 rows (257 at the default); s_tready stays low until it is done.
`default_nettype none

module combination_lexicographic_rank_core #(
    parameter int MAX_SET      = crlr_pkg::MAX_SET_DEF,
    parameter int MAX_UNIVERSE = crlr_pkg::MAX_UNIVERSE_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave stream
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    input  wire logic [crlr_pkg::IN_TDATA_W-1:0]      i_s_tdata,  // elem_0..elem_7, 8b each
    // master stream
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    output logic [crlr_pkg::OUT_TDATA_W-1:0]          o_m_tdata,  // rank[48:0], zero fill
    output logic [0:0]                                o_m_tuser,  // bad_set
    // APB
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [crlr_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [crlr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [crlr_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    localparam int NLANE = (MAX_SET < crlr_pkg::ELEMS) ? MAX_SET : crlr_pkg::ELEMS;
    localparam int NPORT = NLANE + 1;
    localparam int ROWS  = MAX_UNIVERSE + 1;
    localparam int AW    = $clog2(ROWS);
    localparam int CW    = $clog2(MAX_SET + 1);
    localparam int RK    = crlr_pkg::RANK_W;
    localparam int RW    = (MAX_SET + 1) * RK;

    logic [crlr_pkg::USIZE_W-1:0] r_usize;
    logic [crlr_pkg::SSIZE_W-1:0] r_ssize;

    crlr_pkg::t_elem elem [crlr_pkg::ELEMS];
    logic            s_accept;
    logic            ce1;
    logic            ce2;

    logic            fill_busy;
    logic            fill_we;
    logic [AW-1:0]   fill_waddr;
    logic [RW-1:0]   fill_wdata;

    logic            c_valid;
    logic            c_bad;
    logic            c_use  [NLANE];
    logic [CW-1:0]   c_col  [NLANE];
    logic [AW-1:0]   c_addr [NLANE];
    logic [AW-1:0]   c_top_addr;
    logic [CW-1:0]   c_top_col;

    logic [AW-1:0]   rd_addr [NPORT];
    logic [RW-1:0]   rd_data [NPORT];

    logic            r_s2_v;
    logic            r_s2_bad;
    logic            r_s2_use [NLANE];
    logic [CW-1:0]   r_s2_col [NLANE];
    logic [CW-1:0]   r_s2_tcol;

    crlr_pkg::t_rank term [NLANE];
    crlr_pkg::t_rank top_term;

    logic            sum_ready;
    crlr_pkg::t_rank sum_rank;
    logic            sum_bad;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usize <= crlr_pkg::USIZE_RST;
            r_ssize <= crlr_pkg::SSIZE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (crlr_pkg::t_reg_idx'(paddr[2]))
                crlr_pkg::REG_UNIVERSE: r_usize <= pwdata[crlr_pkg::USIZE_W-1:0];
                crlr_pkg::REG_SET_SIZE: r_ssize <= pwdata[crlr_pkg::SSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (crlr_pkg::t_reg_idx'(paddr[2]))
            crlr_pkg::REG_UNIVERSE: prdata = crlr_pkg::APB_DATA_W'(r_usize);
            crlr_pkg::REG_SET_SIZE: prdata = crlr_pkg::APB_DATA_W'(r_ssize);
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Unpack the request
    always_comb begin
        for (int i = 0; i < crlr_pkg::ELEMS; i++) begin
            elem[i] = i_s_tdata[i*crlr_pkg::ELEM_W +: crlr_pkg::ELEM_W];
        end
    end

    // Front stage enables
    assign ce2        = !r_s2_v || sum_ready;
    assign ce1        = !c_valid || ce2;
    assign o_s_tready = ce1 && !fill_busy;
    assign s_accept   = i_s_tvalid && o_s_tready;

    crlr_fill #(
        .MAX_SET      (MAX_SET),
        .MAX_UNIVERSE (MAX_UNIVERSE)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (fill_busy),
        .o_we    (fill_we),
        .o_waddr (fill_waddr),
        .o_wdata (fill_wdata)
    );

    crlr_check #(
        .MAX_SET      (MAX_SET),
        .MAX_UNIVERSE (MAX_UNIVERSE)
    ) u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (ce1),
        .i_load     (s_accept),
        .i_elem     (elem),
        .i_usize    (r_usize),
        .i_ssize    (r_ssize),
        .o_valid    (c_valid),
        .o_bad      (c_bad),
        .o_use      (c_use),
        .o_col      (c_col),
        .o_addr     (c_addr),
        .o_top_addr (c_top_addr),
        .o_top_col  (c_top_col)
    );

    // Read addresses: one per lane, the last port fetches row n for C(n,p)
    always_comb begin
        for (int g = 0; g < NLANE; g++) begin
            rd_addr[g] = c_addr[g];
        end
        rd_addr[NLANE] = c_top_addr;
    end

    for (genvar g = 0; g < NPORT; g++) begin : g_tbl
        crlr_ram #(
            .WIDTH (RW),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (fill_we),
            .i_waddr (fill_waddr),
            .i_wdata (fill_wdata),
            .i_re    (ce2),
            .i_raddr (rd_addr[g]),
            .o_rdata (rd_data[g])
        );
    end

    // Side data that travels alongside the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (ce2) begin
            r_s2_v <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce2) begin
            r_s2_bad  <= c_bad;
            r_s2_tcol <= c_top_col;
            for (int i = 0; i < NLANE; i++) begin
                r_s2_use[i] <= c_use[i];
                r_s2_col[i] <= c_col[i];
            end
        end
    end

    // Column select out of each fetched row
    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            term[i] = r_s2_use[i] ? rd_data[i][r_s2_col[i]*RK +: RK] : '0;
        end
        top_term = rd_data[NLANE][r_s2_tcol*RK +: RK];
    end

    crlr_sum #(
        .MAX_SET (MAX_SET)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .o_ready (sum_ready),
        .i_bad   (r_s2_bad),
        .i_top   (top_term),
        .i_term  (term),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_rank  (sum_rank),
        .o_bad   (sum_bad)
    );

    assign o_m_tdata    = crlr_pkg::OUT_TDATA_W'(sum_rank);
    assign o_m_tuser[0] = sum_bad;

    // No request is taken while the table is still being built
    a_fill_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_busy |-> !o_s_tready)
        else $error("request accepted during table fill");

    // A rejected subset always reports rank zero
    a_bad_rank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("bad subset with nonzero rank");

    // The fill ends right after the last table row is written
    a_fill_ends_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(fill_busy) |-> ($past(fill_waddr) == AW'(ROWS - 1)))
        else $error("table fill ended early");

endmodule

`default_nettype wire

// ===== verif/combination_lexicographic_rank_core_test.sv =====
`default_nettype none

module combination_lexicographic_rank_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIV_MAX = crlr_pkg::MAX_UNIVERSE_DEF;
    localparam int SET_MAX  = crlr_pkg::MAX_SET_DEF;

    // Receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,
        RX_CHOPPY = 2'd1,
        RX_LONG   = 2'd2
    } t_rx_mode;

    typedef struct packed {
        logic [crlr_pkg::RANK_W-1:0] rank;
        logic                        bad;
    } t_rank_result;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_s_tvalid;
    logic                                 o_s_tready;
    logic [crlr_pkg::IN_TDATA_W-1:0]      i_s_tdata;   // elem_0..elem_7, 8b each
    logic                                 o_m_tvalid;
    logic                                 i_m_tready = 1'b0;
    logic [crlr_pkg::OUT_TDATA_W-1:0]     o_m_tdata;   // rank[48:0], zero fill
    logic [0:0]                           o_m_tuser;   // bad_set
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [crlr_pkg::APB_ADDR_W-1:0]      paddr;
    logic [crlr_pkg::APB_DATA_W-1:0]      pwdata;
    logic [crlr_pkg::APB_DATA_W-1:0]      prdata;
    logic                                 pready;

    // Binomial coefficients C(m,k), exact in 64 bits
    logic [63:0] choose_tbl [0:UNIV_MAX][0:SET_MAX];

    // Register shadows
    int unsigned cfg_universe = 32'(crlr_pkg::USIZE_RST);
    int unsigned cfg_set      = 32'(crlr_pkg::SSIZE_RST);

    t_rank_result pending_ranks[$];
    t_rank_result got_want;

    int fails         = 0;
    int ranks_seen    = 0;
    int bad_seen      = 0;
    int settings_used = 1;

    // Traffic shaping
    bit          tx_bursty  = 1'b0;
    int unsigned burst_left = 0;
    t_rx_mode    rx_mode    = RX_OPEN;
    bit          rx_on      = 1'b1;
    int unsigned rx_left    = 0;

    combination_lexicographic_rank_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (rx_mode == RX_OPEN) begin
            i_m_tready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_on   = ~rx_on;
                rx_left = rx_on ? $urandom_range(1, 16)
                                : $urandom_range(1, (rx_mode == RX_LONG) ? 20 : 3);
            end
            rx_left--;
            i_m_tready <= rx_on;
        end
    end

    // Result checker: compare each result with the oldest expected rank
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_ranks.size() == 0) begin
                $error("result with no request outstanding: rank %0d bad_set %0d",
                       o_m_tdata[crlr_pkg::RANK_W-1:0], o_m_tuser[0]);
                fails++;
            end else begin
                got_want = pending_ranks.pop_front();
                ranks_seen++;
                if (got_want.bad)
                    bad_seen++;
                if (o_m_tdata[crlr_pkg::RANK_W-1:0] !== got_want.rank) begin
                    $error("rank mismatch: expected %0d, actual %0d",
                           got_want.rank, o_m_tdata[crlr_pkg::RANK_W-1:0]);
                    fails++;
                end
                if (o_m_tuser[0] !== got_want.bad) begin
                    $error("bad_set mismatch: expected %0d, actual %0d",
                           got_want.bad, o_m_tuser[0]);
                    fails++;
                end
            end
        end
    end

    // Expected rank of one subset under the current register shadows
    function automatic t_rank_result predict_rank(input logic [63:0] subset);
        int unsigned  n, p, i, j, lo, e;
        logic [63:0]  acc;
        logic         bad;
        t_rank_result r;
        n   = (cfg_universe > UNIV_MAX) ? UNIV_MAX : cfg_universe;
        p   = cfg_set;
        bad = (p == 0) || (p > SET_MAX) || (p > crlr_pkg::ELEMS);
        if (!bad) begin
            for (i = 0; i < p; i++) begin
                e = 32'(subset[8*i +: 8]);
                if (e >= n)
                    bad = 1'b1;
                if (i > 0 && e <= 32'(subset[8*(i-1) +: 8]))
                    bad = 1'b1;
            end
        end
        acc = '0;
        if (!bad) begin
            lo = 0;
            for (i = 0; i < p; i++) begin
                e = 32'(subset[8*i +: 8]);
                for (j = lo; j < e; j++)
                    acc += choose_tbl[n-1-j][p-1-i];
                lo = e + 1;
            end
        end
        r.rank = bad ? '0 : acc[crlr_pkg::RANK_W-1:0];
        r.bad  = bad;
        return r;
    endfunction

    // Consecutive indices first..first+count-1 in the low slots, filler above
    function automatic logic [63:0] run_subset(input int unsigned first,
                                               input int unsigned count,
                                               input logic [7:0]  filler);
        logic [63:0] s;
        int unsigned i;
        for (i = 0; i < crlr_pkg::ELEMS; i++)
            s[8*i +: 8] = (i < count) ? 8'(first + i) : filler;
        return s;
    endfunction

    // Mostly well-formed subsets with random content, some broken or pure noise
    function automatic logic [63:0] random_subset();
        logic [63:0]  s;
        logic [255:0] taken;
        logic [7:0]   tmp;
        int unsigned  n, p, lo, span, k, cnt, i, j;
        n = (cfg_universe > UNIV_MAX) ? UNIV_MAX : cfg_universe;
        p = cfg_set;
        s = {$urandom, $urandom};
        if (p == 0 || p > SET_MAX || p > n || $urandom_range(0, 99) < 6)
            return s;
        // pick a window: whole universe, top end (high ranks) or bottom end
        case ($urandom_range(0, 3))
            2: begin
                span = $urandom_range(p, (n < p + 6) ? n : p + 6);
                lo   = n - span;
            end
            3: begin
                span = $urandom_range(p, (n < p + 6) ? n : p + 6);
                lo   = 0;
            end
            default: begin
                span = n;
                lo   = 0;
            end
        endcase
        taken = '0;
        cnt   = 0;
        while (cnt < p) begin
            k = lo + $urandom_range(0, span - 1);
            if (!taken[k]) begin
                taken[k] = 1'b1;
                cnt++;
            end
        end
        j = 0;
        for (i = 0; i < 256; i++) begin
            if (taken[i]) begin
                s[8*j +: 8] = i[7:0];
                j++;
            end
        end
        // break about one in ten
        if ($urandom_range(0, 9) == 0) begin
            k = (p >= 2) ? $urandom_range(0, p - 2) : 0;
            case ($urandom_range(0, 2))
                0: if (p >= 2) begin
                    tmp             = s[8*k +: 8];
                    s[8*k +: 8]     = s[8*k + 8 +: 8];
                    s[8*k + 8 +: 8] = tmp;
                end
                1: if (p >= 2)
                    s[8*k + 8 +: 8] = s[8*k +: 8];
                default: if (n < 256) begin
                    k = $urandom_range(0, p - 1);
                    s[8*k +: 8] = 8'($urandom_range(n, 255));
                end
            endcase
        end
        return s;
    endfunction

    // Register write: setup then access, then the bus goes back to idle
    task automatic apb_write(input crlr_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            crlr_pkg::REG_UNIVERSE: cfg_universe = 32'(value[crlr_pkg::USIZE_W-1:0]);
            crlr_pkg::REG_SET_SIZE: cfg_set      = 32'(value[crlr_pkg::SSIZE_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Register read-back against the shadow
    task automatic apb_read_check(input crlr_pkg::t_reg_idx idx);
        int unsigned want;
        int unsigned got;
        want    = (idx == crlr_pkg::REG_UNIVERSE) ? cfg_universe : cfg_set;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        got = (idx == crlr_pkg::REG_UNIVERSE) ? 32'(prdata[crlr_pkg::USIZE_W-1:0])
                                              : 32'(prdata[crlr_pkg::SSIZE_W-1:0]);
        if (got != want) begin
            $error("%s read-back mismatch: expected %0d, actual %0d",
                   (idx == crlr_pkg::REG_UNIVERSE) ? "universe_size" : "set_size",
                   want, got);
            fails++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Send one request; valid stays high across a burst
    task automatic push_subset(input logic [63:0] subset);
        t_rank_result want;
        int unsigned  gap;
        want = predict_rank(subset);
        if (tx_bursty && burst_left == 0) begin
            gap = $urandom_range(1, 9);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= subset;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pending_ranks.push_back(want);
        @(negedge i_clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stop sending and wait until every expected rank has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_ranks.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Idle the block, then write and read back both registers
    task automatic set_config(input int unsigned usize, input int unsigned ssize);
        drain();
        apb_write(crlr_pkg::REG_UNIVERSE, usize);
        apb_write(crlr_pkg::REG_SET_SIZE, ssize);
        apb_read_check(crlr_pkg::REG_UNIVERSE);
        apb_read_check(crlr_pkg::REG_SET_SIZE);
        settings_used++;
    endtask

    // Reset values, ranked with single-index subsets
    task automatic test_reset_values();
        apb_read_check(crlr_pkg::REG_UNIVERSE);
        apb_read_check(crlr_pkg::REG_SET_SIZE);
        push_subset(run_subset(0, 1, 8'hff));
        push_subset(run_subset(255, 1, 8'h00));
        push_subset(run_subset(128, 1, 8'h5a));
    endtask

    // First and last subsets, widest rank, unordered and repeated indices,
    // universe saturation
    task automatic test_extreme_subsets();
        logic [63:0] s;
        set_config(256, 8);
        push_subset(run_subset(0, 8, 8'h00));
        push_subset(run_subset(248, 8, 8'h00));   // largest rank, all 49 bits
        s = run_subset(10, 8, 8'h00);
        s[31:24] = 8'd14;
        s[39:32] = 8'd13;                         // out of order
        push_subset(s);
        s = run_subset(100, 8, 8'h00);
        s[63:56] = s[55:48];                      // repeated index
        push_subset(s);
        set_config(300, 3);                       // saturates to 256
        push_subset(run_subset(253, 3, 8'hff));
        push_subset(run_subset(0, 3, 8'hff));
        set_config(511, 2);
        push_subset(run_subset(254, 2, 8'hc3));
    endtask

    // Range and size corner cases
    task automatic test_range_and_size_cases();
        set_config(5, 8);                         // set larger than universe
        push_subset(run_subset(0, 8, 8'h00));
        set_config(3, 3);
        push_subset(run_subset(0, 3, 8'hff));
        push_subset({40'hff_ffff_ffff, 8'd3, 8'd1, 8'd0});
        set_config(0, 1);
        push_subset(run_subset(0, 1, 8'h00));
        set_config(1, 1);
        push_subset(run_subset(0, 1, 8'hff));
        set_config(256, 0);                       // empty set
        push_subset(run_subset(0, 8, 8'h00));
        set_config(256, 9);                       // set size beyond the fields
        push_subset(run_subset(0, 8, 8'h00));
        set_config(256, 15);
        push_subset(run_subset(200, 8, 8'h00));
        set_config(100, 4);
        push_subset({32'h0, 8'd100, 8'd3, 8'd2, 8'd1});
        push_subset(run_subset(96, 4, 8'hee));
    endtask

    // Random subsets over a series of register settings and traffic shapes
    task automatic test_random_phases();
        int unsigned usz [10];
        int unsigned ssz [10];
        int unsigned ph, k;
        usz = '{256, 256, 2, 2, 300, 511, 9, 40, 0, 0};
        ssz = '{8, 1, 1, 2, 4, 6, 8, 3, 0, 0};
        usz[8] = $urandom_range(2, 256);
        ssz[8] = $urandom_range(1, 8);
        usz[9] = $urandom_range(2, 511);
        ssz[9] = $urandom_range(1, 8);
        for (ph = 0; ph < 10; ph++) begin
            set_config(usz[ph], ssz[ph]);
            tx_bursty = ph[0];
            rx_mode   = t_rx_mode'(ph % 3);
            for (k = 0; k < 90; k++)
                push_subset(random_subset());
        end
    endtask

    initial begin
        int m, k;
        for (m = 0; m <= UNIV_MAX; m++) begin
            choose_tbl[m][0] = 64'd1;
            for (k = 1; k <= SET_MAX; k++)
                choose_tbl[m][k] = (m == 0) ? 64'd0
                                            : choose_tbl[m-1][k-1] + choose_tbl[m-1][k];
        end
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // table build after reset holds tready low
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        @(negedge i_clk);

        test_reset_values();
        test_extreme_subsets();
        test_range_and_size_cases();
        test_random_phases();

        rx_mode = RX_OPEN;
        drain();
        repeat (20) @(posedge i_clk);

        $display("Ranked %0d subsets (%0d flagged bad) over %0d register settings,",
                 ranks_seen, bad_seen, settings_used);
        $display("with streaming and bursty requests, open and stalling receiver.");
        if (fails == 0 && pending_ranks.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/crlr_pkg.sv
design/crlr_ram.sv
design/crlr_fill.sv
design/crlr_check.sv
design/crlr_sum.sv
design/combination_lexicographic_rank_core.sv
verif/combination_lexicographic_rank_core_test.sv
